// ----- hdl/midi_message_coalescing_queue_unit_macros.svh -----
// Assertion macros shared by the MIDI coalescing queue modules.
`ifndef MIDI_MESSAGE_COALESCING_QUEUE_UNIT_MACROS_SVH
`define MIDI_MESSAGE_COALESCING_QUEUE_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define MMCQ_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define MMCQ_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define MMCQ_ASSERT_NOW(lbl, clk, rst, ante, cons, msg)
`define MMCQ_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// ----- hdl/mmcq_pkg.sv -----
// Types and constants for the MIDI message coalescing queue.
package mmcq_pkg;

   localparam int unsigned CHANNELS = 16;
   localparam int unsigned CH_W     = 4;
   localparam int unsigned SLOTS    = 2 * CHANNELS;   // pitch-bend and CC1 per channel
   localparam int unsigned SLOT_W   = 5;

   localparam logic [3:0] MSG_TYPE_BEND = 4'hE;
   localparam logic [3:0] MSG_TYPE_CC   = 4'hB;
   localparam logic [6:0] CC_MODWHEEL   = 7'd1;
   localparam logic [7:0] FLUSH_INTERVAL_RST = 8'd8;

   localparam logic CSR_ENABLE         = 1'b0;
   localparam logic CSR_FLUSH_INTERVAL = 1'b1;

   localparam logic OP_SUBMIT = 1'b0;
   localparam logic OP_TICK   = 1'b1;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_FLUSH
   } mmcq_state_type;

   typedef enum logic [2:0] {
      RSP_QUEUED    = 3'd0,
      RSP_COALESCED = 3'd1,
      RSP_REJECTED  = 3'd2,
      RSP_DROPPED   = 3'd3,
      RSP_DRAIN     = 3'd4
   } mmcq_status_type;

   typedef struct packed {
      logic [1:0] len;
      logic [7:0] b0;
      logic [7:0] b1;
      logic [7:0] b2;
   } mmcq_entry_type;

   // controller -> datapath
   typedef struct packed {
      logic capture;
      logic do_submit;
      logic do_pop;
      logic do_empty;
      logic scan_step;
   } mmcq_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic op_tick;
      logic enable;
      logic fifo_empty;
      logic flush_due;
      logic pending_any;
      logic more_pending;
   } mmcq_sts_type;

endpackage

// ----- hdl/midi_message_coalescing_queue_unit.sv -----
// Top level of the MIDI message coalescing queue.
//
// Usage: an item (submit or drain tick) is taken when start is high and busy is
// low. Every item gives one or more results; each result is shown for exactly one
// cycle with rsp_valid high and must be taken then, as the receiver has no way
// to hold results off. rsp_last marks the final result of an item.
// Timing: a submission is decoded in the cycle after acceptance and its result
// appears in the cycle after that; busy is high for 1 cycle. A drain tick pops
// at most one queued message in that same decode cycle. If a flush of coalesced
// values follows, the scan walks the 32 slots (channels 0 to 15, pitch-bend then
// CC1 in each) one slot per cycle from slot 0 and stops at the last pending slot,
// so a tick keeps busy high through it and its results come at most one a cycle,
// with gaps where slots are not pending. The one-slot-per-cycle scan sets the
// worst case. The FIFO is a single-port-write, registered-read memory; its
// contents need no clearing after reset.
// CSRs: index 0 enable (bit 0), index 1 flush interval (8 bits). csr_ready is
// always high; writes are expected only while busy is low and no result is due.
module midi_message_coalescing_queue_unit #(
   parameter int unsigned FIFO_DEPTH = 64
) (
   input  logic       clock,
   input  logic       reset,
   // request
   input  logic       start,
   output logic       busy,
   input  logic       req_opcode,
   input  logic [3:0] req_msg_len,
   input  logic [7:0] req_status_byte,
   input  logic [7:0] req_data_byte1,
   input  logic [7:0] req_data_byte2,
   // response
   output logic       rsp_valid,
   output logic       rsp_has_message,
   output logic [1:0] rsp_out_len,
   output logic [7:0] rsp_out_byte0,
   output logic [7:0] rsp_out_byte1,
   output logic [7:0] rsp_out_byte2,
   output logic [2:0] rsp_status,
   output logic       rsp_overwrote_pending,
   output logic       rsp_last,
   // CSR write transfer
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_index,
   input  logic [7:0] csr_data
);
   import mmcq_pkg::*;

   mmcq_cmd_type cmd;
   mmcq_sts_type sts;

   // sequencer: one decode state per item, then the optional flush scan
   mmcq_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .sts   (sts),
      .cmd   (cmd),
      .busy  (busy)
   );

   // storage, decode and the registered result stage
   mmcq_dp #(
      .FIFO_DEPTH (FIFO_DEPTH)
   ) u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .sts                   (sts),
      .req_opcode            (req_opcode),
      .req_msg_len           (req_msg_len),
      .req_status_byte       (req_status_byte),
      .req_data_byte1        (req_data_byte1),
      .req_data_byte2        (req_data_byte2),
      .rsp_valid             (rsp_valid),
      .rsp_has_message       (rsp_has_message),
      .rsp_out_len           (rsp_out_len),
      .rsp_out_byte0         (rsp_out_byte0),
      .rsp_out_byte1         (rsp_out_byte1),
      .rsp_out_byte2         (rsp_out_byte2),
      .rsp_status            (rsp_status),
      .rsp_overwrote_pending (rsp_overwrote_pending),
      .rsp_last              (rsp_last),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_data              (csr_data)
   );

endmodule

// ----- hdl/mmcq_ctrl.sv -----
// Sequencer for the MIDI coalescing queue: decode, pop and flush scan.
`include "midi_message_coalescing_queue_unit_macros.svh"
module mmcq_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  mmcq_pkg::mmcq_sts_type sts,
   output mmcq_pkg::mmcq_cmd_type cmd,
   output logic                 busy
);
   import mmcq_pkg::*;

   mmcq_state_type state_ff;
   mmcq_state_type state_in;
   logic           go_flush;

   // if enabled and pending: flush after a pop at the interval or on an empty FIFO
   assign go_flush = sts.op_tick && sts.enable && sts.pending_any &&
                     (sts.fifo_empty || sts.flush_due);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = go_flush ? S_FLUSH : S_IDLE;
         end
         S_FLUSH: begin
            if (!sts.more_pending) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         S_IDLE: begin
            cmd.capture = start;
         end
         S_EXEC: begin
            priority if (!sts.op_tick) begin
               cmd.do_submit = 1'b1;
            end else if (!sts.enable) begin
               cmd.do_empty = 1'b1;
            end else if (!sts.fifo_empty) begin
               cmd.do_pop = 1'b1;
            end else begin
               // empty FIFO: the scan follows if anything is pending
               cmd.do_empty = !sts.pending_any;
            end
         end
         S_FLUSH: begin
            cmd.scan_step = 1'b1;
         end
         default: cmd = '0;
      endcase
   end

   assign busy = (state_ff != S_IDLE);

   `MMCQ_ASSERT_NEXT(a_start_exec, clock, reset, (state_ff == S_IDLE) && start, state_ff == S_EXEC, "accepted item did not reach decode")
   `MMCQ_ASSERT_NEXT(a_exec_once, clock, reset, state_ff == S_EXEC, state_ff != S_EXEC, "decode held for more than one cycle")
   `MMCQ_ASSERT_NOW(a_flush_pending, clock, reset, state_ff == S_FLUSH, sts.pending_any, "flush scan running with nothing pending")

endmodule

// ----- hdl/mmcq_dp.sv -----
// Datapath: message FIFO, coalesced values, CSRs and result register.
`include "midi_message_coalescing_queue_unit_macros.svh"
module mmcq_dp #(
   parameter int unsigned FIFO_DEPTH = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  mmcq_pkg::mmcq_cmd_type cmd,
   output mmcq_pkg::mmcq_sts_type sts,
   input  logic                   req_opcode,
   input  logic [3:0]             req_msg_len,
   input  logic [7:0]             req_status_byte,
   input  logic [7:0]             req_data_byte1,
   input  logic [7:0]             req_data_byte2,
   output logic                   rsp_valid,
   output logic                   rsp_has_message,
   output logic [1:0]             rsp_out_len,
   output logic [7:0]             rsp_out_byte0,
   output logic [7:0]             rsp_out_byte1,
   output logic [7:0]             rsp_out_byte2,
   output logic [2:0]             rsp_status,
   output logic                   rsp_overwrote_pending,
   output logic                   rsp_last,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic                   csr_index,
   input  logic [7:0]             csr_data
);
   import mmcq_pkg::*;

   localparam int unsigned PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FIFO_DEPTH);

   // csr
   logic       enable_ff;
   logic [7:0] flush_interval_ff;

   // captured request
   logic       opcode_ff;
   logic [3:0] len_ff;
   logic [7:0] sb_ff;
   logic [7:0] d1_ff;
   logic [7:0] d2_ff;

   // fifo
   mmcq_entry_type   fifo_mem [FIFO_DEPTH];
   mmcq_entry_type   rd_entry_ff;
   mmcq_entry_type   wr_entry;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             fifo_push;

   // coalesced values
   logic [CHANNELS-1:0] bend_pend_ff, bend_pend_in;
   logic [CHANNELS-1:0] mod_pend_ff, mod_pend_in;
   logic [13:0]         bend_val_ff [CHANNELS];
   logic [6:0]          mod_val_ff [CHANNELS];
   logic [SLOTS-1:0]    pend_vec;
   logic [SLOTS-1:0]    pend_above;
   logic [SLOT_W-1:0]   scan_idx_ff, scan_idx_in;
   logic [CH_W-1:0]     scan_ch;
   logic                scan_hit;

   logic [7:0] sent_ff, sent_in, sent_next;

   // submit decode
   logic [CH_W-1:0] sub_ch;
   logic            is_bend, is_mod, rejected;
   logic [1:0]      qlen;

   // result register
   logic            rsp_valid_ff, rsp_valid_in;
   logic            has_ff, has_in;
   logic [1:0]      olen_ff, olen_in;
   logic [7:0]      ob0_ff, ob0_in, ob1_ff, ob1_in, ob2_ff, ob2_in;
   mmcq_status_type st_ff, st_in;
   logic            ovw_ff, ovw_in;
   logic            last_ff, last_in;

   // ---------------- csr ----------------
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff         <= 1'b0;
         flush_interval_ff <= FLUSH_INTERVAL_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_ENABLE:         enable_ff         <= csr_data[0];
            CSR_FLUSH_INTERVAL: flush_interval_ff <= csr_data;
            default:            enable_ff         <= enable_ff;
         endcase
      end
   end

   // ---------------- request capture ----------------
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         opcode_ff <= req_opcode;
         len_ff    <= req_msg_len;
         sb_ff     <= req_status_byte;
         d1_ff     <= req_data_byte1;
         d2_ff     <= req_data_byte2;
      end
   end

   // ---------------- submit decode ----------------
   assign sub_ch   = sb_ff[CH_W-1:0];
   assign rejected = !enable_ff || (len_ff == 4'd0);
   assign is_bend  = (len_ff == 4'd3) && (sb_ff[7:4] == MSG_TYPE_BEND);
   assign is_mod   = (len_ff == 4'd3) && (sb_ff[7:4] == MSG_TYPE_CC) &&
                     (d1_ff[6:0] == CC_MODWHEEL);
   assign qlen     = (len_ff > 4'd3) ? 2'd3 : len_ff[1:0];

   always_comb begin
      wr_entry.len = qlen;
      wr_entry.b0  = sb_ff;
      wr_entry.b1  = (qlen > 2'd1) ? d1_ff : 8'd0;
      wr_entry.b2  = (qlen > 2'd2) ? d2_ff : 8'd0;
   end

   assign fifo_push = cmd.do_submit && !rejected && !is_bend && !is_mod &&
                      (count_ff < CNT_FULL);

   // ---------------- fifo ----------------
   // read port runs every cycle; a write is stored before its pop's read is registered
   always_ff @(posedge clock) begin
      if (fifo_push) fifo_mem[wr_ptr_ff] <= wr_entry;
      rd_entry_ff <= fifo_mem[rd_ptr_ff];
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (fifo_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
         count_in  = count_ff + CNT_W'(1);
      end
      if (cmd.do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
         count_in  = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // ---------------- flush interval counter ----------------
   assign sent_next = sent_ff + 8'd1;

   always_comb begin
      sent_in = sent_ff;
      if (cmd.do_pop) sent_in = (sent_next >= flush_interval_ff) ? 8'd0 : sent_next;
   end

   always_ff @(posedge clock) begin
      if (reset) sent_ff <= 8'd0;
      else       sent_ff <= sent_in;
   end

   // ---------------- coalesced values and scan ----------------
   // slot = {channel, kind}; kind 0 is pitch-bend, 1 is CC1
   always_comb begin
      for (int c = 0; c < CHANNELS; c++) begin
         pend_vec[2*c]   = bend_pend_ff[c];
         pend_vec[2*c+1] = mod_pend_ff[c];
      end
   end

   assign scan_ch    = scan_idx_ff[SLOT_W-1:1];
   assign scan_hit   = pend_vec[scan_idx_ff];
   assign pend_above = pend_vec & ~(({{(SLOTS-1){1'b0}}, 1'b1} << scan_idx_ff << 1)
                                    - {{(SLOTS-1){1'b0}}, 1'b1});

   always_comb begin
      bend_pend_in = bend_pend_ff;
      mod_pend_in  = mod_pend_ff;
      scan_idx_in  = scan_idx_ff;
      if (cmd.do_submit && !rejected) begin
         if (is_bend)     bend_pend_in[sub_ch] = 1'b1;
         else if (is_mod) mod_pend_in[sub_ch]  = 1'b1;
      end
      if (cmd.capture) scan_idx_in = '0;
      if (cmd.scan_step) begin
         scan_idx_in = scan_idx_ff + SLOT_W'(1);
         if (scan_idx_ff[0]) mod_pend_in[scan_ch]  = 1'b0;
         else                bend_pend_in[scan_ch] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bend_pend_ff <= '0;
         mod_pend_ff  <= '0;
         scan_idx_ff  <= '0;
      end else begin
         bend_pend_ff <= bend_pend_in;
         mod_pend_ff  <= mod_pend_in;
         scan_idx_ff  <= scan_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.do_submit && !rejected && is_bend)
         bend_val_ff[sub_ch] <= {d2_ff[6:0], d1_ff[6:0]};
      if (cmd.do_submit && !rejected && !is_bend && is_mod)
         mod_val_ff[sub_ch] <= d2_ff[6:0];
   end

   // ---------------- status ----------------
   always_comb begin
      sts.op_tick      = (opcode_ff == OP_TICK);
      sts.enable       = enable_ff;
      sts.fifo_empty   = (count_ff == '0);
      sts.flush_due    = (sent_next >= flush_interval_ff);
      sts.pending_any  = |pend_vec;
      sts.more_pending = |pend_above;
   end

   // ---------------- result ----------------
   always_comb begin
      rsp_valid_in = 1'b0;
      has_in       = 1'b0;
      olen_in      = 2'd0;
      ob0_in       = 8'd0;
      ob1_in       = 8'd0;
      ob2_in       = 8'd0;
      st_in        = RSP_DRAIN;
      ovw_in       = 1'b0;
      last_in      = 1'b1;
      priority if (cmd.do_submit) begin
         rsp_valid_in = 1'b1;
         priority if (rejected) begin
            st_in = RSP_REJECTED;
         end else if (is_bend) begin
            st_in  = RSP_COALESCED;
            ovw_in = bend_pend_ff[sub_ch];
         end else if (is_mod) begin
            st_in  = RSP_COALESCED;
            ovw_in = mod_pend_ff[sub_ch];
         end else if (!fifo_push) begin
            st_in = RSP_DROPPED;
         end else begin
            st_in = RSP_QUEUED;
         end
      end else if (cmd.do_pop) begin
         rsp_valid_in = 1'b1;
         has_in       = 1'b1;
         olen_in      = rd_entry_ff.len;
         ob0_in       = rd_entry_ff.b0;
         ob1_in       = rd_entry_ff.b1;
         ob2_in       = rd_entry_ff.b2;
         last_in      = !(sts.flush_due && sts.pending_any);
      end else if (cmd.do_empty) begin
         rsp_valid_in = 1'b1;
      end else if (cmd.scan_step && scan_hit) begin
         rsp_valid_in = 1'b1;
         has_in       = 1'b1;
         olen_in      = 2'd3;
         last_in      = !sts.more_pending;
         if (scan_idx_ff[0]) begin
            ob0_in = {MSG_TYPE_CC, scan_ch};
            ob1_in = {1'b0, CC_MODWHEEL};
            ob2_in = {1'b0, mod_val_ff[scan_ch]};
         end else begin
            ob0_in = {MSG_TYPE_BEND, scan_ch};
            ob1_in = {1'b0, bend_val_ff[scan_ch][6:0]};
            ob2_in = {1'b0, bend_val_ff[scan_ch][13:7]};
         end
      end else begin
         // idle, or a scan slot with nothing pending
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      has_ff  <= has_in;
      olen_ff <= olen_in;
      ob0_ff  <= ob0_in;
      ob1_ff  <= ob1_in;
      ob2_ff  <= ob2_in;
      st_ff   <= st_in;
      ovw_ff  <= ovw_in;
      last_ff <= last_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_has_message       = has_ff;
   assign rsp_out_len           = olen_ff;
   assign rsp_out_byte0         = ob0_ff;
   assign rsp_out_byte1         = ob1_ff;
   assign rsp_out_byte2         = ob2_ff;
   assign rsp_status            = st_ff;
   assign rsp_overwrote_pending = ovw_ff;
   assign rsp_last              = last_ff;

   `MMCQ_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_FULL, "fifo count beyond depth")
   `MMCQ_ASSERT_NOW(a_pop_nonempty, clock, reset, cmd.do_pop, count_ff != '0, "pop from an empty fifo")
   `MMCQ_ASSERT_NOW(a_msg_is_drain, clock, reset, rsp_valid_ff && has_ff, st_ff == RSP_DRAIN, "message carried by a submission result")

endmodule

// ----- tb/sv/midi_message_coalescing_queue_unit_tb.sv -----
// Self-checking testbench for the MIDI message coalescing queue unit.
`timescale 1ns / 100ps

module midi_message_coalescing_queue_unit_tb;
   import mmcq_pkg::*;

   localparam int unsigned DEPTH       = 64;
   // A tick may keep busy high through a whole flush scan; allow a margin.
   localparam int unsigned TAIL_CYCLES = 40;
   // Slowest run: ~270 items, each at its longest busy and idle time, many times over.
   localparam int unsigned CYCLE_LIMIT = 400000;

   // One result as the block should present it.
   typedef struct {
      logic            has_message;
      logic [1:0]      out_len;
      logic [7:0]      byte0;
      logic [7:0]      byte1;
      logic [7:0]      byte2;
      mmcq_status_type status;
      logic            overwrote;
      logic            last;
   } midi_rsp_type;

   // ---------------------------------------------------------------- DUT ports
   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       start = 1'b0;
   logic       busy;
   logic       req_opcode = OP_SUBMIT;
   logic [3:0] req_msg_len = 4'd0;
   logic [7:0] req_status_byte = 8'h00;
   logic [7:0] req_data_byte1 = 8'h00;
   logic [7:0] req_data_byte2 = 8'h00;
   logic       rsp_valid;
   logic       rsp_has_message;
   logic [1:0] rsp_out_len;
   logic [7:0] rsp_out_byte0;
   logic [7:0] rsp_out_byte1;
   logic [7:0] rsp_out_byte2;
   logic [2:0] rsp_status;
   logic       rsp_overwrote_pending;
   logic       rsp_last;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic       csr_index = CSR_ENABLE;
   logic [7:0] csr_data = 8'h00;

   // --------------------------------------------------------- predicted state
   logic                cfg_enable;
   logic [7:0]          cfg_flush_interval;
   mmcq_entry_type      fifo_mem [DEPTH];
   int unsigned         fifo_rd;
   int unsigned         fifo_wr;
   int unsigned         fifo_fill;
   logic [CHANNELS-1:0] bend_pend;
   logic [CHANNELS-1:0] wheel_pend;
   logic [13:0]         bend_val  [CHANNELS];
   logic [6:0]          wheel_val [CHANNELS];
   logic [7:0]          sent_count;

   midi_rsp_type awaited_rsp [$];   // results due, oldest first
   int unsigned  mismatches  = 0;
   int unsigned  cycle_count = 0;
   int unsigned  idle_pct    = 0;   // chance (%) of the sender pausing before an item

   midi_message_coalescing_queue_unit #(
      .FIFO_DEPTH(DEPTH)
   ) i_dut (
      .clock                 (clock),
      .reset                 (reset),
      .start                 (start),
      .busy                  (busy),
      .req_opcode            (req_opcode),
      .req_msg_len           (req_msg_len),
      .req_status_byte       (req_status_byte),
      .req_data_byte1        (req_data_byte1),
      .req_data_byte2        (req_data_byte2),
      .rsp_valid             (rsp_valid),
      .rsp_has_message       (rsp_has_message),
      .rsp_out_len           (rsp_out_len),
      .rsp_out_byte0         (rsp_out_byte0),
      .rsp_out_byte1         (rsp_out_byte1),
      .rsp_out_byte2         (rsp_out_byte2),
      .rsp_status            (rsp_status),
      .rsp_overwrote_pending (rsp_overwrote_pending),
      .rsp_last              (rsp_last),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_data              (csr_data)
   );

   always #5 clock = ~clock;

   // Watchdog: a hung handshake or a lost result ends the run here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[midi_message_coalescing_queue_unit] ERROR");
         $finish;
      end
   end

   task automatic report_mismatch(string line);
      $display("MISMATCH @%0t: %s", $realtime, line);
      mismatches++;
   endtask

   // ---------------------------------------------------------------- predictor
   task automatic push_rsp(logic has, logic [1:0] len, logic [7:0] b0, logic [7:0] b1,
                           logic [7:0] b2, mmcq_status_type st, logic ovw);
      midi_rsp_type r;
      r.has_message = has;
      r.out_len     = len;
      r.byte0       = b0;
      r.byte1       = b1;
      r.byte2       = b2;
      r.status      = st;
      r.overwrote   = ovw;
      r.last        = 1'b0;
      awaited_rsp.push_back(r);
   endtask

   // Scan channels in order: pitch-bend first, then mod wheel, clearing each flag.
   task automatic flush_coalesced(inout int unsigned made);
      logic [3:0] chn;
      for (int c = 0; c < CHANNELS; c++) begin
         chn = c[3:0];
         if (bend_pend[chn]) begin
            bend_pend[chn] = 1'b0;
            push_rsp(1'b1, 2'd3, {MSG_TYPE_BEND, chn}, {1'b0, bend_val[chn][6:0]},
                     {1'b0, bend_val[chn][13:7]}, RSP_DRAIN, 1'b0);
            made++;
         end
         if (wheel_pend[chn]) begin
            wheel_pend[chn] = 1'b0;
            push_rsp(1'b1, 2'd3, {MSG_TYPE_CC, chn}, {1'b0, CC_MODWHEEL},
                     {1'b0, wheel_val[chn]}, RSP_DRAIN, 1'b0);
            made++;
         end
      end
   endtask

   // Works out every result that one accepted item causes, and updates the state.
   task automatic coalesce_predict(logic op, logic [3:0] len, logic [7:0] s,
                                   logic [7:0] d1, logic [7:0] d2);
      logic [3:0]     chn;
      mmcq_entry_type e;
      int unsigned    made;
      chn  = s[3:0];
      made = 0;
      if (op == OP_SUBMIT) begin
         if (!cfg_enable || len == 4'd0) begin
            push_rsp(1'b0, 2'd0, 8'h00, 8'h00, 8'h00, RSP_REJECTED, 1'b0);
         end else if (len == 4'd3 && s[7:4] == MSG_TYPE_BEND) begin
            push_rsp(1'b0, 2'd0, 8'h00, 8'h00, 8'h00, RSP_COALESCED, bend_pend[chn]);
            bend_pend[chn] = 1'b1;
            bend_val[chn]  = {d2[6:0], d1[6:0]};
         end else if (len == 4'd3 && s[7:4] == MSG_TYPE_CC && d1[6:0] == CC_MODWHEEL) begin
            push_rsp(1'b0, 2'd0, 8'h00, 8'h00, 8'h00, RSP_COALESCED, wheel_pend[chn]);
            wheel_pend[chn] = 1'b1;
            wheel_val[chn]  = d2[6:0];
         end else if (fifo_fill >= DEPTH) begin
            push_rsp(1'b0, 2'd0, 8'h00, 8'h00, 8'h00, RSP_DROPPED, 1'b0);
         end else begin
            // long messages are cut to three bytes, unused bytes read as zero
            e.len = (len > 4'd3) ? 2'd3 : len[1:0];
            e.b0  = s;
            e.b1  = (e.len > 2'd1) ? d1 : 8'h00;
            e.b2  = (e.len > 2'd2) ? d2 : 8'h00;
            fifo_mem[fifo_wr] = e;
            fifo_wr = (fifo_wr == DEPTH - 1) ? 0 : fifo_wr + 1;
            fifo_fill++;
            push_rsp(1'b0, 2'd0, 8'h00, 8'h00, 8'h00, RSP_QUEUED, 1'b0);
         end
         made = 1;
      end else begin
         if (cfg_enable) begin
            if (fifo_fill > 0) begin
               e = fifo_mem[fifo_rd];
               fifo_rd = (fifo_rd == DEPTH - 1) ? 0 : fifo_rd + 1;
               fifo_fill--;
               push_rsp(1'b1, e.len, e.b0, e.b1, e.b2, RSP_DRAIN, 1'b0);
               made++;
               sent_count = sent_count + 8'd1;
               // also covers an interval of zero and one lowered below the count
               if (sent_count >= cfg_flush_interval) begin
                  sent_count = 8'd0;
                  flush_coalesced(made);
               end
            end else begin
               flush_coalesced(made);
            end
         end
         // disabled tick, or nothing queued or pending: a single empty result
         if (made == 0) begin
            push_rsp(1'b0, 2'd0, 8'h00, 8'h00, 8'h00, RSP_DRAIN, 1'b0);
         end
      end
      awaited_rsp[awaited_rsp.size() - 1].last = 1'b1;
   endtask

   // ------------------------------------------------------------------ checker
   // Results cannot be held off, so every strobe is a transfer.
   always @(posedge clock) begin : check_rsp
      midi_rsp_type want;
      if (!reset && rsp_valid) begin
         if (awaited_rsp.size() == 0) begin
            report_mismatch($sformatf("result with none due, status %0d", rsp_status));
         end else begin
            want = awaited_rsp.pop_front();
            if (rsp_has_message !== want.has_message)
               report_mismatch($sformatf("has_message got %0b want %0b",
                                         rsp_has_message, want.has_message));
            if (rsp_out_len !== want.out_len)
               report_mismatch($sformatf("out_len got %0d want %0d",
                                         rsp_out_len, want.out_len));
            if (rsp_out_byte0 !== want.byte0)
               report_mismatch($sformatf("out_byte0 got %02h want %02h",
                                         rsp_out_byte0, want.byte0));
            if (rsp_out_byte1 !== want.byte1)
               report_mismatch($sformatf("out_byte1 got %02h want %02h",
                                         rsp_out_byte1, want.byte1));
            if (rsp_out_byte2 !== want.byte2)
               report_mismatch($sformatf("out_byte2 got %02h want %02h",
                                         rsp_out_byte2, want.byte2));
            if (rsp_status !== want.status)
               report_mismatch($sformatf("status got %0d want %0d",
                                         rsp_status, want.status));
            if (rsp_overwrote_pending !== want.overwrote)
               report_mismatch($sformatf("overwrote_pending got %0b want %0b",
                                         rsp_overwrote_pending, want.overwrote));
            if (rsp_last !== want.last)
               report_mismatch($sformatf("last got %0b want %0b", rsp_last, want.last));
         end
      end
   end

   // ---------------------------------------------------------------- stimulus
   // Presents one item and holds it until the transfer. start is left high so
   // that a following item goes back to back; settle() lowers it.
   task automatic send_item(logic op, logic [3:0] len, logic [7:0] s,
                            logic [7:0] d1, logic [7:0] d2);
      if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      start           <= 1'b1;
      req_opcode      <= op;
      req_msg_len     <= len;
      req_status_byte <= s;
      req_data_byte1  <= d1;
      req_data_byte2  <= d2;
      @(posedge clock);
      while (busy) @(posedge clock);
      coalesce_predict(op, len, s, d1, d2);
   endtask

   task automatic submit(logic [3:0] len, logic [7:0] s, logic [7:0] d1, logic [7:0] d2);
      send_item(OP_SUBMIT, len, s, d1, d2);
   endtask

   // Tick fields are don't-care; fill them with noise.
   task automatic tick();
      logic [31:0] rnd;
      rnd = $urandom;
      send_item(OP_TICK, rnd[3:0], rnd[11:4], rnd[19:12], rnd[27:20]);
   endtask

   // Stops sending and waits until the block has gone quiet.
   task automatic settle();
      start <= 1'b0;
      while (awaited_rsp.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [7:0] data);
      settle();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_ENABLE) cfg_enable = data[0];
      else                   cfg_flush_interval = data;
      csr_valid <= 1'b0;
   endtask

   // Enable lives in bit 0; the other bits carry noise.
   task automatic set_enable(logic on);
      logic [31:0] rnd;
      rnd    = $urandom;
      rnd[0] = on;
      write_csr(CSR_ENABLE, rnd[7:0]);
   endtask

   // Mostly well-formed traffic: bends and mod wheel on a few busy channels,
   // ordinary messages and ticks, plus some raw noise.
   task automatic send_random_item(int unsigned tick_pct);
      logic [31:0] rnd;
      logic [31:0] rnd2;
      logic [3:0]  chn;
      int unsigned kind;
      rnd  = $urandom;
      rnd2 = $urandom;
      chn  = rnd[16] ? {2'b00, rnd[18:17]} : rnd[22:19];
      kind = $urandom_range(0, 99);
      if (kind < tick_pct) begin
         send_item(OP_TICK, rnd2[3:0], rnd2[11:4], rnd[7:0], rnd[15:8]);
      end else begin
         kind = $urandom_range(0, 99);
         if (kind < 30)
            submit(4'd3, {MSG_TYPE_BEND, chn}, rnd[7:0], rnd[15:8]);
         else if (kind < 55)
            submit(4'd3, {MSG_TYPE_CC, chn}, {rnd[7], CC_MODWHEEL}, rnd[15:8]);
         else if (kind < 90)
            submit(4'($urandom_range(1, 15)), rnd2[7:0], rnd[7:0], rnd[15:8]);
         else
            send_item(rnd2[31], rnd2[3:0], rnd2[15:8], rnd[7:0], rnd[15:8]);
      end
   endtask

   // ------------------------------------------------------------------ tests
   // Straight out of reset the block is disabled.
   task automatic test_disabled();
      idle_pct = 0;
      submit(4'd3, {MSG_TYPE_BEND, 4'd1}, 8'h12, 8'h34);
      submit(4'd2, 8'h92, 8'h40, 8'h00);
      tick();
      settle();
   endtask

   // Every submission kind but a drop, drained with the reset flush interval of 8.
   task automatic test_submit_kinds();
      set_enable(1'b1);
      submit(4'd0,  8'h90, 8'h3C, 8'h40);                  // zero length
      submit(4'd1,  8'hC5, 8'hAA, 8'h55);
      submit(4'd2,  8'hD3, 8'hFF, 8'hFF);
      submit(4'd3,  8'h90, 8'h7F, 8'h80);
      submit(4'd15, 8'hFF, 8'hFF, 8'hFF);                  // truncated
      submit(4'd4,  8'h00, 8'h00, 8'h00);
      submit(4'd2,  {MSG_TYPE_BEND, 4'd4}, 8'h10, 8'h20);  // short bend is queued
      submit(4'd3,  {MSG_TYPE_CC, 4'd3}, 8'h02, 8'h7F);    // other controller
      submit(4'd4,  {MSG_TYPE_CC, 4'd3}, 8'h01, 8'h55);    // CC1 of wrong length
      submit(4'd3,  {MSG_TYPE_BEND, 4'd0}, 8'hFF, 8'h80);  // masked to 7 bits
      submit(4'd3,  {MSG_TYPE_BEND, 4'd15}, 8'h00, 8'h7F);
      submit(4'd3,  {MSG_TYPE_BEND, 4'd15}, 8'h7F, 8'h00); // overwrite
      submit(4'd3,  {MSG_TYPE_CC, 4'd3}, 8'h81, 8'hFF);    // CC1 after masking
      submit(4'd3,  {MSG_TYPE_CC, 4'd3}, 8'h01, 8'h00);    // overwrite
      repeat (8) tick();                                   // eighth one flushes
      tick();                                              // nothing left at all
      submit(4'd3,  {MSG_TYPE_BEND, 4'd7}, 8'h01, 8'h02);
      tick();                                              // empty FIFO flushes
      settle();
   endtask

   task automatic test_flush_interval();
      write_csr(CSR_FLUSH_INTERVAL, 8'd0);                 // flush after every pop
      submit(4'd2, 8'hC1, 8'h05, 8'h00);
      submit(4'd3, {MSG_TYPE_BEND, 4'd2}, 8'h11, 8'h22);
      tick();
      submit(4'd3, {MSG_TYPE_CC, 4'd9}, 8'h01, 8'h40);
      tick();
      write_csr(CSR_FLUSH_INTERVAL, 8'd255);
      for (int i = 0; i < 5; i++) submit(4'd2, 8'h80 | 8'(i), 8'(i), 8'h00);
      submit(4'd3, {MSG_TYPE_CC, 4'd14}, 8'h01, 8'h33);
      repeat (3) tick();
      write_csr(CSR_FLUSH_INTERVAL, 8'd2);                 // now below the count
      tick();
      write_csr(CSR_FLUSH_INTERVAL, 8'd1);
      tick();
      submit(4'd1, 8'hF8, 8'h00, 8'h00);
      submit(4'd3, {MSG_TYPE_BEND, 4'd5}, 8'h7F, 8'h7F);
      set_enable(1'b0);
      tick();                                              // must leave state alone
      submit(4'd1, 8'hFA, 8'h00, 8'h00);
      set_enable(1'b1);
      tick();
      tick();
      settle();
   endtask

   // Fill past full, coalesce while full, then drain across the pointer wrap.
   task automatic test_fifo_full();
      logic [31:0] rnd;
      idle_pct = 0;
      write_csr(CSR_FLUSH_INTERVAL, 8'd255);
      for (int i = 0; i < DEPTH + 3; i++) begin
         rnd = $urandom;
         submit(4'($urandom_range(1, 15)), {4'h9, rnd[3:0]}, rnd[15:8], rnd[23:16]);
      end
      submit(4'd3, {MSG_TYPE_BEND, 4'd10}, 8'h55, 8'h2A);
      submit(4'd3, {MSG_TYPE_CC, 4'd10}, 8'h01, 8'h11);
      repeat (DEPTH + 1) tick();
      settle();
   endtask

   task automatic random_phase(int unsigned pct, logic [7:0] interval, int unsigned items);
      int unsigned tick_pct;
      write_csr(CSR_FLUSH_INTERVAL, interval);
      idle_pct = pct;
      tick_pct = 35;
      for (int unsigned n = 0; n < items; n++) begin
         // vary the mix so the FIFO fills up and runs dry in turn
         if (n % 17 == 0) tick_pct = $urandom_range(15, 60);
         send_random_item(tick_pct);
      end
      settle();
   endtask

   task automatic test_random();
      random_phase(0,  8'd8, 22);
      random_phase(45, 8'($urandom_range(0, 15)), 22);
      random_phase(33, 8'd255, 22);
      set_enable(1'b0);
      idle_pct = 0;
      repeat (6) send_random_item(40);
      set_enable(1'b1);
      random_phase(0,  8'd1, 16);
   endtask

   // -------------------------------------------------------------------- main
   initial begin
      cfg_enable         = 1'b0;
      cfg_flush_interval = FLUSH_INTERVAL_RST;
      fifo_rd            = 0;
      fifo_wr            = 0;
      fifo_fill          = 0;
      bend_pend          = '0;
      wheel_pend         = '0;
      sent_count         = 8'd0;
      for (int c = 0; c < CHANNELS; c++) begin
         bend_val[c]  = '0;
         wheel_val[c] = '0;
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_disabled();
      test_submit_kinds();
      test_flush_interval();
      test_fifo_full();
      test_random();

      settle();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("[midi_message_coalescing_queue_unit] OK");
      end else begin
         $display("[midi_message_coalescing_queue_unit] ERROR");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/mmcq_pkg.sv
hdl/mmcq_ctrl.sv
hdl/mmcq_dp.sv
hdl/midi_message_coalescing_queue_unit.sv
tb/sv/midi_message_coalescing_queue_unit_tb.sv
